[src/dbm_pkg.sv]
// ----------------------------------------------------------------------------
// dbm_pkg
// Shared constants and codes for the dual bitmap allocator.
// ----------------------------------------------------------------------------
package dbm_pkg;

	localparam int MAP_BYTES_DEF = 512;
	localparam int INDEX_BYTES   = 512;
	localparam int WORD_BYTES    = 8;
	localparam int WORD_W        = WORD_BYTES * 8;
	localparam int IDX_W         = 12;
	localparam int ACT_W         = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

endpackage

[src/dual_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// dual_bitmap_allocator
// Inode and data block allocation bitmaps with set, clear and find-first-free.
//
//   channel | dir | tdata                  | tuser
//   s_*     | in  | bit_index [11:0]       | action [1:0], map_select [2]
//   m_*     | out | free_index [11:0]      | found [0]
//
// Each map is a RAM of 64-bit words (eight bytes). Set and clear go from
// acceptance to result through a read, a modify-write and a result step. A
// find reads one word per cycle with the next read overlapping the check, and
// reads up to ceil(min(MAP_BYTES,512)/8) words, 64 at the default size.
// After reset a clearing pass writes zeros over ceil(MAP_BYTES/8) words, one
// per cycle, before the first transaction is taken. One request is in flight
// at a time; a held result stalls the request only at its result step.
// ----------------------------------------------------------------------------
module dual_bitmap_allocator
	import dbm_pkg::*;
#(
	parameter int MAP_BYTES = MAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // bit_index [11:0], zero [15:12]
	input  logic [2:0]  s_tuser,   // action [1:0], map_select [2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // free_index [11:0], zero [15:12]
	output logic [0:0]  m_tuser    // found [0]
);

	localparam int WORDS      = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SCAN_BYTES = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;
	localparam int SCAN_WORDS = (SCAN_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int LAST_BYTES = SCAN_BYTES - WORD_BYTES * (SCAN_WORDS - 1);

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_RD   = 6'b000100,
		ST_MOD  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_RESP = 6'b100000
	} state_t;

	state_t            state_q;
	logic [WAW-1:0]    clr_q;
	logic [WAW-1:0]    iss_q;
	logic [WAW-1:0]    chk_q;
	logic              chk_valid_q;
	logic              map_q;
	action_t           act_q;
	logic [IDX_W-1:0]  idx_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_index_q;

	logic              in_acc;
	logic              out_free;
	action_t           in_act;
	logic [IDX_W-1:0]  in_idx;
	logic              in_range;
	logic [WAW-1:0]    req_word;

	logic              we_ino;
	logic              we_blk;
	logic [WAW-1:0]    waddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic [WAW-1:0]    raddr;
	logic [WORD_W-1:0] rdata_ino;
	logic [WORD_W-1:0] rdata_blk;
	logic [WORD_W-1:0] rword;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] mod_word;

	logic              chk_last;
	logic [7:0]        byte_hit;
	logic              word_hit;
	logic [2:0]        sel_k;
	logic [2:0]        sel_j;
	logic [7:0]        sel_byte;
	logic [IDX_W-1:0]  hit_index;

	assign in_act   = action_t'(s_tuser[1:0]);
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_range = (32'(in_idx[IDX_W-1:3]) < 32'(MAP_BYTES));
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign req_word = WAW'(idx_q[IDX_W-1:6]);
	assign rword    = map_q ? rdata_blk : rdata_ino;
	assign bit_mask = WORD_W'(1) << {idx_q[5:3], ~idx_q[2:0]};
	assign mod_word = (act_q == ACT_SET) ? (rword | bit_mask) : (rword & ~bit_mask);

	always_comb begin
		we_ino = 1'b0;
		we_blk = 1'b0;
		waddr  = clr_q;
		wdata  = '0;
		re     = 1'b0;
		raddr  = iss_q;
		unique case (state_q)
			ST_CLR: begin
				we_ino = 1'b1;
				we_blk = 1'b1;
			end
			ST_RD: begin
				re    = 1'b1;
				raddr = req_word;
			end
			ST_MOD: begin
				we_ino = !map_q;
				we_blk = map_q;
				waddr  = req_word;
				wdata  = mod_word;
			end
			ST_SCAN: begin
				re = !(chk_valid_q && (word_hit || chk_last));
			end
			default: begin
			end
		endcase
	end

	dbm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (WAW)
	) u_inode_ram (
		.clk   (clk),
		.we    (we_ino),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_ino)
	);

	dbm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (WAW)
	) u_block_ram (
		.clk   (clk),
		.we    (we_blk),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_blk)
	);

	assign chk_last = (chk_q == WAW'(SCAN_WORDS - 1));

	always_comb begin
		for (int k = 0; k < WORD_BYTES; k++) begin
			byte_hit[k] = (!chk_last || (k < LAST_BYTES)) && (rword[8*k +: 8] != 8'hFF);
		end
		word_hit = |byte_hit;
		sel_k    = '0;
		for (int k = WORD_BYTES - 1; k >= 0; k--) begin
			if (byte_hit[k]) begin
				sel_k = 3'(k);
			end
		end
		sel_byte = rword[8*sel_k +: 8];
		sel_j    = '0;
		for (int j = 7; j >= 0; j--) begin
			if (!sel_byte[7-j]) begin
				sel_j = 3'(j);
			end
		end
		hit_index = IDX_W'({chk_q, sel_k, sel_j});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			iss_q       <= '0;
			chk_q       <= '0;
			chk_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + WAW'(1);
					if (clr_q == WAW'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						iss_q       <= '0;
						chk_valid_q <= 1'b0;
						if ((in_act == ACT_SET || in_act == ACT_CLEAR) && in_range) begin
							state_q <= ST_RD;
						end else if (in_act == ACT_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if (chk_valid_q && (word_hit || chk_last)) begin
						state_q <= ST_RESP;
					end else begin
						chk_q       <= iss_q;
						chk_valid_q <= 1'b1;
						iss_q       <= iss_q + WAW'(1);
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q       <= in_act;
			map_q       <= s_tuser[2];
			idx_q       <= in_idx;
			res_found_q <= 1'b0;
			res_index_q <= '0;
		end
		if (state_q == ST_SCAN && chk_valid_q && word_hit) begin
			res_found_q <= 1'b1;
			res_index_q <= hit_index;
		end
		if (state_q == ST_RESP && out_free) begin
			out_found_q <= res_found_q;
			out_index_q <= res_index_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 16'(out_index_q);
	assign m_tuser  = out_found_q;

endmodule

[src/dbm_ram.sv]
// ----------------------------------------------------------------------------
// dbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual bitmap allocator.
//
// Set, clear and find-first-free requests go to both maps. A shadow copy of
// each map predicts every result as the request is taken. Results are checked
// in order. Coverage includes directed corner cases, long scans over filled
// words, a long output stall, a stretch with no gaps, and random
// allocate/free traffic. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	import dbm_pkg::*;

	localparam int MAP_BITS    = MAP_BYTES_DEF * 8;
	localparam int SCAN_BITS   = (MAP_BYTES_DEF < INDEX_BYTES ? MAP_BYTES_DEF : INDEX_BYTES) * 8;
	localparam int FILL_BITS   = 128;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 100;
	localparam int IDLE_PCT    = 29;
	localparam int PRINT_CAP   = 100;

	localparam logic             SEL_INODE = 1'b0;
	localparam logic             SEL_BLOCK = 1'b1;
	localparam logic [IDX_W-1:0] IDX_MAX   = '1;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] free_index;
	} alloc_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // bit_index [11:0], zero [15:12]
	logic [2:0]  s_tuser  = '0;   // action [1:0], map_select [2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // free_index [11:0], zero [15:12]
	logic [0:0]  m_tuser;         // found [0]

	logic          shadow_map [2][MAP_BITS] = '{default: '0};
	alloc_result_t pending_results[$];
	alloc_result_t last_prediction;
	int            mismatches     = 0;
	int            sent_count     = 0;
	int            src_idle_pct   = IDLE_PCT;
	int            sink_stall_pct = IDLE_PCT;
	int            sink_hold      = 0;
	int            cycle_count    = 0;

	dual_bitmap_allocator #(
		.MAP_BYTES(MAP_BYTES_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic alloc_result_t bitmap_apply(action_t act, logic sel,
			logic [IDX_W-1:0] idx);
		alloc_result_t res;
		res = '0;
		case (act)
			ACT_SET:   if (idx < MAP_BITS) shadow_map[sel][idx] = 1'b1;
			ACT_CLEAR: if (idx < MAP_BITS) shadow_map[sel][idx] = 1'b0;
			ACT_FIND: begin
				for (int n = 0; n < SCAN_BITS && !res.found; n++) begin
					if (!shadow_map[sel][n]) begin
						res.found      = 1'b1;
						res.free_index = IDX_W'(n);
					end
				end
			end
			ACT_NONE: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_req(action_t act, logic sel, logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, idx};
		s_tuser  <= {sel, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		last_prediction = bitmap_apply(act, sel, idx);
		pending_results.push_back(last_prediction);
		sent_count++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", int'(m_tdata[IDX_W-1:0]), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[0] !== want.found)
					report_mismatch("found", int'(m_tuser[0]), int'(want.found));
				if (m_tdata[IDX_W-1:0] !== want.free_index)
					report_mismatch("free_index", int'(m_tdata[IDX_W-1:0]),
						int'(want.free_index));
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_bitmap_allocator verification failed");
			$finish;
		end
	end

	task automatic test_directed();
		send_req(ACT_FIND, SEL_INODE, '0);
		send_req(ACT_FIND, SEL_BLOCK, IDX_MAX);
		send_req(ACT_SET, SEL_INODE, '0);
		send_req(ACT_SET, SEL_INODE, IDX_MAX);
		send_req(ACT_FIND, SEL_INODE, '0);
		// inode clear must really clear
		send_req(ACT_CLEAR, SEL_INODE, '0);
		send_req(ACT_FIND, SEL_INODE, '0);
		send_req(ACT_SET, SEL_BLOCK, 12'd1);
		send_req(ACT_SET, SEL_BLOCK, '0);
		send_req(ACT_FIND, SEL_BLOCK, '0);
		// fill byte 0 so the scan must skip it
		for (int n = 2; n < 8; n++)
			send_req(ACT_SET, SEL_BLOCK, IDX_W'(n));
		send_req(ACT_FIND, SEL_BLOCK, IDX_MAX);
		send_req(ACT_CLEAR, SEL_BLOCK, 12'd2048);
		send_req(ACT_SET, SEL_INODE, IDX_MAX);
		send_req(ACT_NONE, SEL_INODE, IDX_MAX);
		send_req(ACT_NONE, SEL_BLOCK, '0);
		send_req(ACT_CLEAR, SEL_BLOCK, 12'd5);
		send_req(ACT_FIND, SEL_BLOCK, '0);
		wait_idle();
	endtask

	task automatic test_deep_scan();
		for (int m = 0; m < 2; m++) begin
			for (int n = 0; n < FILL_BITS; n++)
				send_req(ACT_SET, 1'(m), IDX_W'(n));
			send_req(ACT_FIND, 1'(m), '0);
			send_req(ACT_CLEAR, 1'(m), IDX_MAX);
			send_req(ACT_FIND, 1'(m), IDX_MAX);
			send_req(ACT_SET, 1'(m), IDX_MAX);
		end
		wait_idle();
	endtask

	task automatic test_random(int n_items);
		int               stop_at;
		int               pick;
		logic             sel;
		logic [IDX_W-1:0] idx;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			pick = int'($urandom_range(99));
			sel  = 1'($urandom_range(1));
			idx  = IDX_W'($urandom_range(IDX_MAX));
			if (pick < 35) begin
				// allocate: find, then claim the unit found
				send_req(ACT_FIND, sel, idx);
				if (last_prediction.found)
					idx = last_prediction.free_index;
				send_req(ACT_SET, sel, idx);
			end else if (pick < 55) begin
				send_req(ACT_CLEAR, sel, idx);
			end else if (pick < 68) begin
				send_req(ACT_SET, sel, idx);
			end else if (pick < 80) begin
				send_req(ACT_FIND, sel, idx);
			end else if (pick < 85) begin
				send_req(ACT_NONE, sel, idx);
			end else begin
				// free a unit, then allocate again
				send_req(ACT_CLEAR, sel, idx);
				send_req(ACT_FIND, sel, idx);
				send_req(ACT_SET, sel, last_prediction.free_index);
			end
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		sink_hold = 400;
		test_random(12);
	endtask

	task automatic test_no_gaps();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random(200);
		src_idle_pct   = IDLE_PCT;
		sink_stall_pct = IDLE_PCT;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deep_scan();
		test_backpressure();
		test_no_gaps();
		test_random(1100);
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("dual_bitmap_allocator verification clean");
		else
			$display("dual_bitmap_allocator verification failed");
		$finish;
	end

endmodule
